[hdl/srp_pkg.sv]
package srp_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int RECT_W_BITS   = 11;
    localparam int RECT_H_BITS   = 16;
    localparam int POS_X_BITS    = 10;
    localparam int ATLAS_W_BITS  = 11;
    localparam int GAP_BITS      = 8;
    localparam int CURSOR_BITS   = 12;
    localparam int CFG_DATA_BITS = 11;
    localparam int TDATA_BITS    = 32;

    // Default number of skyline columns held on chip.
    localparam int DEF_MAX_COLUMNS = 1024;

    // Saturation limits.
    localparam logic [CURSOR_BITS-1:0] CURSOR_MAX = '1;
    localparam logic [RECT_H_BITS-1:0] HEIGHT_MAX = '1;

    // Operation codes carried in tuser.
    localparam logic OP_PLACE     = 1'b0;
    localparam logic OP_NEW_ATLAS = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ATLAS_WIDTH = 1'b0;
    localparam logic CFG_COLUMN_GAP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch the accepted item and set up the placement
        logic scan;      // read one skyline column
        logic rewind;    // return the column pointer to the placement start
        logic write_col; // raise one skyline column
        logic clear_col; // zero one skyline column
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_new;    // incoming item starts a new atlas
        logic too_wide;  // incoming rectangle is wider than the atlas
        logic zero_w;    // incoming rectangle has no columns
        logic cnt_last;  // last column of the current run
        logic addr_last; // pointer is at the last skyline column
    } t_sts;

endpackage

[hdl/skyline_rect_packer.sv]
// Skyline rectangle packer. Each input beat either starts a new atlas (tuser 1) or places
// one rectangle (tuser 0); every input beat yields exactly one output beat. A rectangle
// goes at the horizontal cursor, which wraps to column 0 when the rectangle would pass
// the atlas edge; it sits on the highest skyline column it covers, those columns are
// raised by its height (saturating at 65535), and the cursor moves on by the width plus
// the configured gap. A rectangle wider than the atlas comes back flagged too_wide at
// position 0,0 and changes nothing. The single-port skyline memory is read once per column
// and then written once per column, and a new atlas runs a clearing sweep over all
// MAX_COLUMNS columns; s_axis_tready stays low from an accepted beat until its result is
// loaded into the output register. After reset the block runs the same clearing sweep
// with s_axis_tready low.
// Configuration writes are taken in any cycle but belong to idle periods.
module skyline_rect_packer
    import srp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_BITS-1:0]    s_axis_tdata,  // rect_width[10:0], rect_height[26:11]
    input  logic                     s_axis_tuser,  // op
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDATA_BITS-1:0]    m_axis_tdata,  // pos_x[9:0], pos_y[25:10]
    output logic                     m_axis_tuser   // too_wide
);

    t_cmd                   cmd;
    t_sts                   sts;
    logic [POS_X_BITS-1:0]  pos_x;
    logic [RECT_H_BITS-1:0] pos_y;

    srp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    srp_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (s_axis_tuser),
        .i_rect_width  (s_axis_tdata[RECT_W_BITS-1:0]),
        .i_rect_height (s_axis_tdata[RECT_W_BITS+RECT_H_BITS-1:RECT_W_BITS]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y),
        .o_too_wide    (m_axis_tuser)
    );

    // Pack the result fields, zero filled to whole bytes.
    assign m_axis_tdata = {{(TDATA_BITS - POS_X_BITS - RECT_H_BITS){1'b0}}, pos_y, pos_x};

endmodule

[hdl/srp_dp.sv]
module srp_dp
    import srp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_op,
    input  logic [RECT_W_BITS-1:0]   i_rect_width,
    input  logic [RECT_H_BITS-1:0]   i_rect_height,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic [POS_X_BITS-1:0]    o_pos_x,
    output logic [RECT_H_BITS-1:0]   o_pos_y,
    output logic                     o_too_wide
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WB = CURSOR_BITS + 1;

    logic [ATLAS_W_BITS-1:0] r_atlas_width;
    logic [GAP_BITS-1:0]     r_column_gap;
    logic [CURSOR_BITS-1:0]  r_cursor;
    logic [CURSOR_BITS-1:0]  r_pos_x;
    logic [CW-1:0]           r_addr;
    logic [RECT_W_BITS-1:0]  r_count;
    logic [RECT_W_BITS-1:0]  r_run_w;
    logic [RECT_H_BITS-1:0]  r_height;
    logic [RECT_H_BITS-1:0]  r_top;
    logic                    r_wide;
    logic                    r_rd_vld;
    logic [RECT_H_BITS-1:0]  r_rd_data;
    logic [POS_X_BITS-1:0]   r_out_x;
    logic [RECT_H_BITS-1:0]  r_out_y;
    logic                    r_out_wide;
    logic [RECT_H_BITS-1:0]  r_skyline [MAX_COLUMNS];

    logic [ATLAS_W_BITS-1:0] eff_width;
    logic [WB-1:0]           cur_end;
    logic                    wrap;
    logic [CURSOR_BITS-1:0]  place_x;
    logic [WB-1:0]           next_sum;
    logic [CURSOR_BITS-1:0]  next_cursor;
    logic [RECT_H_BITS:0]    raise_sum;
    logic [RECT_H_BITS-1:0]  raised;
    logic                    mem_we;
    logic [RECT_H_BITS-1:0]  mem_wdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_width <= ATLAS_W_BITS'(1024);
            r_column_gap  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ATLAS_WIDTH: r_atlas_width <= i_cfg_wdata[ATLAS_W_BITS-1:0];
                CFG_COLUMN_GAP:  r_column_gap  <= i_cfg_wdata[GAP_BITS-1:0];
                default:         r_column_gap  <= r_column_gap;
            endcase
        end
    end

    // Usable atlas width, placement column and the cursor that follows it.
    always_comb begin
        if (WB'(r_atlas_width) > WB'(MAX_COLUMNS)) begin
            eff_width = ATLAS_W_BITS'(MAX_COLUMNS);
        end else begin
            eff_width = r_atlas_width;
        end
        cur_end  = WB'(r_cursor) + WB'(i_rect_width);
        wrap     = (r_cursor >= CURSOR_BITS'(eff_width)) || (cur_end > WB'(eff_width));
        place_x  = wrap ? '0 : r_cursor;
        next_sum = WB'(place_x) + WB'(i_rect_width) + WB'(r_column_gap);
        if (next_sum > WB'(CURSOR_MAX)) begin
            next_cursor = CURSOR_MAX;
        end else begin
            next_cursor = next_sum[CURSOR_BITS-1:0];
        end
    end

    // New column height, saturating at the field maximum.
    always_comb begin
        raise_sum = {1'b0, r_top} + {1'b0, r_height};
        raised    = raise_sum[RECT_H_BITS] ? HEIGHT_MAX : raise_sum[RECT_H_BITS-1:0];
    end

    assign o_sts.is_new    = (i_op == OP_NEW_ATLAS);
    assign o_sts.too_wide  = (i_rect_width > eff_width);
    assign o_sts.zero_w    = (i_rect_width == '0);
    assign o_sts.cnt_last  = (r_count == RECT_W_BITS'(1));
    assign o_sts.addr_last = (r_addr == CW'(MAX_COLUMNS - 1));

    // Item setup, column pointer and run counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_addr   <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_pos_x  <= '0;
            r_wide   <= 1'b0;
            r_height <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                if (o_sts.is_new) begin
                    r_cursor <= '0;
                    r_addr   <= '0;
                    r_pos_x  <= '0;
                    r_wide   <= 1'b0;
                end else if (o_sts.too_wide) begin
                    r_pos_x  <= '0;
                    r_wide   <= 1'b1;
                end else begin
                    r_cursor <= next_cursor;
                    r_addr   <= place_x[CW-1:0];
                    r_pos_x  <= place_x;
                    r_wide   <= 1'b0;
                end
                r_count  <= i_rect_width;
                r_height <= i_rect_height;
            end else if (i_cmd.rewind) begin
                r_addr  <= r_pos_x[CW-1:0];
                r_count <= r_run_w;
            end else if (i_cmd.scan || i_cmd.write_col || i_cmd.clear_col) begin
                r_addr  <= r_addr + CW'(1);
                r_count <= r_count - RECT_W_BITS'(1);
            end
        end
    end

    // Width of the current run, kept for the write pass.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_run_w <= i_rect_width;
        end
    end

    // Running maximum over the scanned columns.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_top <= '0;
        end else if (r_rd_vld && (r_rd_data > r_top)) begin
            r_top <= r_rd_data;
        end
    end

    // Skyline memory: one port, registered read.
    assign mem_we    = i_cmd.write_col || i_cmd.clear_col;
    assign mem_wdata = i_cmd.clear_col ? '0 : raised;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_skyline[r_addr] <= mem_wdata;
        end
        r_rd_data <= r_skyline[r_addr];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x    <= r_pos_x[POS_X_BITS-1:0];
            r_out_y    <= r_top;
            r_out_wide <= r_wide;
        end
    end

    assign o_pos_x    = r_out_x;
    assign o_pos_y    = r_out_y;
    assign o_too_wide = r_out_wide;

endmodule

[hdl/srp_ctrl.sv]
module srp_ctrl
    import srp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_RESULT
    } t_state;

    t_state r_state;
    logic   r_clr_res;
    logic   r_out_vld;
    logic   accept;
    logic   out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_vld || i_m_tready;
    assign o_m_tvalid = r_out_vld;

    // Commands follow the state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = accept;
        o_cmd.scan      = (r_state == ST_SCAN);
        o_cmd.rewind    = (r_state == ST_DRAIN);
        o_cmd.write_col = (r_state == ST_WRITE);
        o_cmd.clear_col = (r_state == ST_CLEAR);
        o_cmd.load_out  = (r_state == ST_RESULT) && out_free;
    end

    // Sequencer and output valid flag. Reset starts with a clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_res <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        priority if (i_sts.is_new) begin
                            r_state   <= ST_CLEAR;
                            r_clr_res <= 1'b1;
                        end else if (i_sts.too_wide || i_sts.zero_w) begin
                            r_state <= ST_RESULT;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_CLEAR: begin
                    if (i_sts.addr_last) begin
                        r_state <= r_clr_res ? ST_RESULT : ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (i_sts.cnt_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (i_sts.cnt_last) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_vld || i_m_tready))
        else $error("result loaded over a waiting beat");

    // A new-atlas beat always leads into the clearing pass.
    a_new_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sts.is_new) |=> (r_state == ST_CLEAR))
        else $error("new atlas did not start a clearing pass");

    // The output only becomes valid out of the result step.
    a_valid_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_RESULT))
        else $error("output valid rose outside the result step");

    // A column run always ends with the drain step before writing.
    a_scan_then_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.cnt_last) |=> (r_state == ST_DRAIN))
        else $error("scan did not drain");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import srp_pkg::*;

    localparam int MAX_COLS   = DEF_MAX_COLUMNS;
    localparam int DIR_ROWS   = 27;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int EXP_DEPTH  = 16;

    // One placement result as it comes back on the master side.
    typedef struct packed {
        logic [POS_X_BITS-1:0]  x;
        logic [RECT_H_BITS-1:0] y;
        logic                   wide;
    } t_pos;

    typedef enum logic {
        ROW_RECT,
        ROW_CFG
    } t_row_kind;

    // A row either sends one rectangle beat or writes one register. For register rows
    // the op column holds the register index and the width column holds the value.
    typedef struct packed {
        t_row_kind              kind;
        logic                   op;
        logic [RECT_W_BITS-1:0] w;
        logic [RECT_H_BITS-1:0] h;
        logic                   known;
        logic [POS_X_BITS-1:0]  x;
        logic [RECT_H_BITS-1:0] y;
        logic                   wide;
    } t_stim_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic                     i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [TDATA_BITS-1:0]    s_axis_tdata;  // rect_width[10:0], rect_height[26:11]
    logic                     s_axis_tuser;  // op
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [TDATA_BITS-1:0]    m_axis_tdata;  // pos_x[9:0], pos_y[25:10]
    logic                     m_axis_tuser;  // too_wide

    // Shadow copy of the packer state and its registers.
    logic [RECT_H_BITS-1:0] sky [0:MAX_COLS-1];
    int                     cursor;
    int                     atlas_w;
    int                     col_gap;

    // Expected results in send order, kept as a small ring.
    t_pos exp_mem [0:EXP_DEPTH-1];
    int   exp_wr;
    int   exp_rd;
    int   err_count;
    bit   feed_idle_on;
    bit   sink_idle_on;

    // Directed rows, reset configuration first (width 1024, gap 0).
    //  kind      op / index       w / value  h           known x        y          wide
    t_stim_row directed [DIR_ROWS] = '{
        '{ROW_RECT, OP_PLACE,       11'd0,    16'd0,     1'b1, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1024, 16'd65535, 1'b1, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1,    16'd5,     1'b1, 10'd0,    16'd65535, 1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1025, 16'd1,     1'b1, 10'd0,    16'd0,     1'b1},
        '{ROW_RECT, OP_PLACE,       11'd2047, 16'd65535, 1'b1, 10'd0,    16'd0,     1'b1},
        '{ROW_RECT, OP_NEW_ATLAS,   11'd2047, 16'd65535, 1'b1, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd10,   16'd100,   1'b1, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd20,   16'd50,    1'b1, 10'd10,   16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd15,   16'd7,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_CFG,  CFG_COLUMN_GAP, 11'd255,  16'd0,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd5,    16'd3,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1000, 16'd1,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1024, 16'd0,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_CFG,  CFG_ATLAS_WIDTH, 11'd1,   16'd0,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1,    16'd1,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd2,    16'd1,     1'b1, 10'd0,    16'd0,     1'b1},
        '{ROW_RECT, OP_PLACE,       11'd0,    16'd9,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_CFG,  CFG_ATLAS_WIDTH, 11'd0,   16'd0,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1,    16'd1,     1'b1, 10'd0,    16'd0,     1'b1},
        '{ROW_RECT, OP_PLACE,       11'd0,    16'd0,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_CFG,  CFG_ATLAS_WIDTH, 11'd2047, 16'd0,    1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_CFG,  CFG_COLUMN_GAP, 11'd0,    16'd0,     1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_NEW_ATLAS,   11'd0,    16'd0,     1'b1, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1000, 16'd1,     1'b1, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd24,   16'd2,     1'b1, 10'd1000, 16'd0,     1'b0},
        '{ROW_RECT, OP_PLACE,       11'd1,    16'd65535, 1'b0, 10'd0,    16'd0,     1'b0},
        '{ROW_RECT, OP_NEW_ATLAS,   11'd1024, 16'd0,     1'b1, 10'd0,    16'd0,     1'b0}
    };

    skyline_rect_packer #(
        .MAX_COLUMNS(MAX_COLS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Works out where the packer puts one rectangle and updates the shadow state.
    function automatic t_pos place_rect(logic op, logic [RECT_W_BITS-1:0] w,
                                        logic [RECT_H_BITS-1:0] h);
        t_pos res;
        int   eff;
        int   width_i;
        int   top;
        int   raised;
        int   nxt;
        int   col;
        res     = '0;
        width_i = w;
        eff     = (atlas_w < MAX_COLS) ? atlas_w : MAX_COLS;
        // A new atlas wipes the skyline and the cursor.
        if (op == OP_NEW_ATLAS) begin
            for (col = 0; col < MAX_COLS; col++) begin
                sky[col] = '0;
            end
            cursor = 0;
            return res;
        end
        // A rectangle that cannot fit at all changes nothing.
        if (width_i > eff) begin
            res.wide = 1'b1;
            return res;
        end
        if (cursor >= eff || cursor + width_i > eff) begin
            cursor = 0;
        end
        top = 0;
        for (col = cursor; col < cursor + width_i && col < MAX_COLS; col++) begin
            if (sky[col] > top) begin
                top = sky[col];
            end
        end
        raised = top + h;
        if (raised > HEIGHT_MAX) begin
            raised = HEIGHT_MAX;
        end
        for (col = cursor; col < cursor + width_i && col < MAX_COLS; col++) begin
            sky[col] = raised[RECT_H_BITS-1:0];
        end
        res.x = cursor[POS_X_BITS-1:0];
        res.y = top[RECT_H_BITS-1:0];
        nxt = cursor + width_i + col_gap;
        if (nxt > CURSOR_MAX) begin
            nxt = CURSOR_MAX;
        end
        cursor = nxt;
        return res;
    endfunction

    // Sends one beat and holds it until accepted, then idles for a random spell.
    task automatic push_rect(logic op, logic [RECT_W_BITS-1:0] w, logic [RECT_H_BITS-1:0] h,
                             logic known, t_pos typed_pos);
        t_pos predicted;
        int   gap_cycles;
        predicted = place_rect(op, w, h);
        exp_mem[exp_wr % EXP_DEPTH] = known ? typed_pos : predicted;
        exp_wr++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_BITS - RECT_H_BITS - RECT_W_BITS){1'b0}}, h, w};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        gap_cycles = feed_idle_on ? $urandom_range(0, 7) : 0;
        if (gap_cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge i_clk);
        end
    endtask

    // Lets the block drain, then writes one register.
    task automatic write_reg(logic idx, logic [CFG_DATA_BITS-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_ATLAS_WIDTH) begin
            atlas_w = val;
        end else begin
            col_gap = val[GAP_BITS-1:0];
        end
    endtask

    // Result side: random stalls, then compare each beat with the oldest prediction.
    initial begin
        int   stall;
        t_pos got;
        t_pos want;
        m_axis_tready <= 1'b0;
        forever begin
            stall = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.x    = m_axis_tdata[POS_X_BITS-1:0];
            got.y    = m_axis_tdata[POS_X_BITS +: RECT_H_BITS];
            got.wide = m_axis_tuser;
            if (exp_wr == exp_rd) begin
                err_count++;
                $display("%0t: unexpected beat: expected none, got x=%0d y=%0d too_wide=%0d",
                         $time, got.x, got.y, got.wide);
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got !== want) begin
                    err_count++;
                    $display("%0t: mismatch: expected x=%0d y=%0d too_wide=%0d,",
                             $time, want.x, want.y, want.wide,
                             " got x=%0d y=%0d too_wide=%0d", got.x, got.y, got.wide);
                end
            end
        end
    end

    // Stimulus: directed rows, then random phases with fresh register settings.
    initial begin
        int               r;
        int               ph;
        int               n;
        int               sel;
        int               eff;
        int               wv;
        int               hv;
        logic             opv;
        logic [CFG_DATA_BITS-1:0] width_val;
        logic [CFG_DATA_BITS-1:0] gap_val;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_ATLAS_WIDTH;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PLACE;
        err_count     = 0;
        exp_wr        = 0;
        exp_rd        = 0;
        feed_idle_on  = 1'b1;
        sink_idle_on  = 1'b1;
        for (n = 0; n < MAX_COLS; n++) begin
            sky[n] = '0;
        end
        cursor  = 0;
        atlas_w = 1024;
        col_gap = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (r = 0; r < DIR_ROWS; r++) begin
            if (directed[r].kind == ROW_CFG) begin
                write_reg(directed[r].op, directed[r].w);
            end else begin
                push_rect(directed[r].op, directed[r].w, directed[r].h, directed[r].known,
                          {directed[r].x, directed[r].y, directed[r].wide});
            end
        end

        // Random phases.
        for (ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       width_val = 11'd1024;
                1:       width_val = CFG_DATA_BITS'($urandom_range(1025, 2047));
                2:       width_val = CFG_DATA_BITS'($urandom_range(1, 16));
                3:       width_val = CFG_DATA_BITS'($urandom_range(1, 1024));
                4:       width_val = 11'd1;
                default: width_val = CFG_DATA_BITS'($urandom_range(64, 256));
            endcase
            case ($urandom_range(0, 3))
                0:       gap_val = 11'd0;
                1:       gap_val = 11'd255;
                default: gap_val = CFG_DATA_BITS'($urandom_range(0, 255));
            endcase
            write_reg(CFG_ATLAS_WIDTH, width_val);
            write_reg(CFG_COLUMN_GAP, gap_val);
            feed_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            eff = (atlas_w < MAX_COLS) ? atlas_w : MAX_COLS;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                opv = OP_PLACE;
                if (sel < 4) begin
                    // Occasional fresh atlas with junk in the other fields.
                    opv = OP_NEW_ATLAS;
                    wv  = $urandom_range(0, 2047);
                end else if (sel < 9) begin
                    wv = $urandom_range(eff + 1, 2047);
                end else if (sel < 12) begin
                    wv = $urandom_range(0, eff);
                end else begin
                    wv = $urandom_range(0, (eff < 48) ? eff : 48);
                end
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    hv = $urandom_range(60000, 65535);
                end else if (sel < 25) begin
                    hv = $urandom_range(0, 65535);
                end else begin
                    hv = $urandom_range(0, 2000);
                end
                push_rect(opv, wv[RECT_W_BITS-1:0], hv[RECT_H_BITS-1:0], 1'b0, '0);
            end
        end

        // Drain, let the block settle, and report.
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (2 * MAX_COLS + 16) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
